// ----- hw/rtl/rhdc_pkg.sv -----
// ----------------------------------------------------------------------------
// Request header deframe check: shared package
// Types, codes and constants used by the header checker and its multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package rhdc_pkg;

  // Header framing.
  localparam int unsigned HeaderLen  = 25;
  localparam int unsigned StoreDepth = HeaderLen - 1;
  localparam int unsigned IdxW       = $clog2(HeaderLen);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(HeaderLen - 1);

  // Byte offsets of the header fields.
  localparam int unsigned OffMagic   = 0;
  localparam int unsigned OffVersion = 4;
  localparam int unsigned OffFlags   = 5;
  localparam int unsigned OffSeq     = 6;
  localparam int unsigned OffWidth   = 10;
  localparam int unsigned OffHeight  = 14;
  localparam int unsigned OffChan    = 18;
  localparam int unsigned OffPayload = 19;
  localparam int unsigned OffChain   = 23;

  // Largest channel count that the mask can allow.
  localparam logic [7:0] MaxChannels = 8'd8;

  // Configuration register reset values.
  localparam logic [31:0] MagicRst      = 32'h0000_0000;
  localparam logic [7:0]  VersionRst    = 8'd1;
  localparam logic [31:0] MaxPayloadRst = 32'hFFFF_FFFF;
  localparam logic [15:0] MaxChainRst   = 16'hFFFF;
  localparam logic [7:0]  ChanMaskRst   = 8'd13;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAGIC        = 3'd0,
    CFG_VERSION      = 3'd1,
    CFG_MAX_PAYLOAD  = 3'd2,
    CFG_MAX_CHAIN    = 3'd3,
    CFG_CHANNEL_MASK = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    STATUS_OK           = 3'd0,
    STATUS_BAD_MAGIC    = 3'd1,
    STATUS_BAD_VERSION  = 3'd2,
    STATUS_PAYLOAD_BIG  = 3'd3,
    STATUS_BAD_CHAIN    = 3'd4,
    STATUS_LEN_MISMATCH = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    DISP_CONTINUE = 2'd0,
    DISP_DRAIN    = 2'd1,
    DISP_CLOSE    = 2'd2
  } disp_e;

  typedef enum logic [1:0] {
    ST_RECV   = 2'd0,
    ST_MUL_WH = 2'd1,
    ST_MUL_CH = 2'd2,
    ST_DONE   = 2'd3
  } state_e;

  // Request to the shared multiplier.
  typedef struct packed {
    logic        en;
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rhdc_mul.sv -----
// ----------------------------------------------------------------------------
// Request header deframe check: shared multiplier
// One registered 32 by 32 bit multiplier, reused by the sequencer for both
// steps of the dimension product.
// ----------------------------------------------------------------------------
`default_nettype none

module rhdc_mul (
  input  wire logic               clk_i,
  input  wire rhdc_pkg::mul_req_t req_i,
  output logic [63:0]             prod_o
);

  logic [63:0] prod_q;

  // The product is held until the next request.
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= 64'(req_i.a) * 64'(req_i.b);
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ----- hw/rtl/request_header_deframe_check.sv -----
// ----------------------------------------------------------------------------
// Request header deframe check
// Collects a 25-byte little-endian request header one byte at a time, checks
// it against the configuration registers and returns the decoded fields with
// a status and a disposition.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                  Payload
//  -------  ---------  -------------------------  ---------------------------
//  in       sink       in_valid_i / in_ready_o    data_byte_i
//  out      source     out_valid_o / out_ready_i  status_o .. chain_length_o
//  cfg      sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
//  Header bytes are taken one per cycle. After the last byte the shared
//  multiplier runs twice (width*height, then times channels) and the result
//  is loaded into the output register in the done state. Input is not taken
//  in the product and done states, nor is the last byte of a header taken
//  while the previous result still waits in the output register.
//  Reset clears the byte position, the sequencer and the output valid, and
//  loads the register defaults; the header store has no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module request_header_deframe_check (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,

  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [1:0]       disposition_o,
  output logic [7:0]       flags_o,
  output logic [31:0]      sequence_res_o,
  output logic [31:0]      img_width_o,
  output logic [31:0]      img_height_o,
  output logic [7:0]       channel_count_o,
  output logic [31:0]      payload_length_o,
  output logic [15:0]      chain_length_o,

  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [rhdc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [rhdc_pkg::CfgDataW-1:0] cfg_data_i
);

  typedef logic [7:0] hdr_store_t [rhdc_pkg::StoreDepth];

  // Little-endian 32-bit field from the header store.
  function automatic logic [31:0] le32(hdr_store_t s, int unsigned off);
    logic [rhdc_pkg::IdxW-1:0] k;
    k = off[rhdc_pkg::IdxW-1:0];
    return {s[k+3'd3], s[k+3'd2], s[k+3'd1], s[k]};
  endfunction

  // Configuration registers.
  logic [31:0] magic_q;
  logic [7:0]  version_q;
  logic [31:0] max_payload_q;
  logic [15:0] max_chain_q;
  logic [7:0]  chan_mask_q;

  // Sequencer and framing state.
  rhdc_pkg::state_e           state_q, state_d;
  logic [rhdc_pkg::IdxW-1:0]  byte_idx_q, byte_idx_d;
  hdr_store_t                 hdr_q;
  logic [7:0]                 chain_hi_q;
  rhdc_pkg::status_e          early_q, early_d;
  logic                       wh_hi_q;

  // Output register.
  logic                       out_valid_q, out_valid_d;
  rhdc_pkg::status_e          status_q, status_d;
  rhdc_pkg::disp_e            disp_q, disp_d;
  logic [7:0]                 flags_q;
  logic [31:0]                seq_q, width_q, height_q, plen_q;
  logic [7:0]                 chan_q;
  logic [15:0]                clen_q;

  // Multiplier interface.
  rhdc_pkg::mul_req_t mul_req;
  logic [63:0]        mul_prod;

  logic in_fire, last_byte, chan_ok;

  // Decoded header fields.
  logic [31:0] dec_magic, dec_seq, dec_width, dec_height, dec_plen;
  logic [7:0]  dec_version, dec_flags, dec_chan;
  logic [15:0] dec_clen;

  assign dec_magic   = le32(hdr_q, rhdc_pkg::OffMagic);
  assign dec_version = hdr_q[rhdc_pkg::OffVersion];
  assign dec_flags   = hdr_q[rhdc_pkg::OffFlags];
  assign dec_seq     = le32(hdr_q, rhdc_pkg::OffSeq);
  assign dec_width   = le32(hdr_q, rhdc_pkg::OffWidth);
  assign dec_height  = le32(hdr_q, rhdc_pkg::OffHeight);
  assign dec_chan    = hdr_q[rhdc_pkg::OffChan];
  assign dec_plen    = le32(hdr_q, rhdc_pkg::OffPayload);
  assign dec_clen    = {chain_hi_q, hdr_q[rhdc_pkg::OffChain]};

  // Input handshake.
  assign last_byte  = (byte_idx_q == rhdc_pkg::LastIdx);
  assign in_ready_o = (state_q == rhdc_pkg::ST_RECV) && !(last_byte && out_valid_q);
  assign in_fire    = in_valid_i && in_ready_o;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q       <= rhdc_pkg::MagicRst;
      version_q     <= rhdc_pkg::VersionRst;
      max_payload_q <= rhdc_pkg::MaxPayloadRst;
      max_chain_q   <= rhdc_pkg::MaxChainRst;
      chan_mask_q   <= rhdc_pkg::ChanMaskRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rhdc_pkg::CFG_MAGIC:        magic_q       <= cfg_data_i;
        rhdc_pkg::CFG_VERSION:      version_q     <= cfg_data_i[7:0];
        rhdc_pkg::CFG_MAX_PAYLOAD:  max_payload_q <= cfg_data_i;
        rhdc_pkg::CFG_MAX_CHAIN:    max_chain_q   <= cfg_data_i[15:0];
        rhdc_pkg::CFG_CHANNEL_MASK: chan_mask_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Byte position within the header.
  always_comb begin
    byte_idx_d = byte_idx_q;
    if (in_fire) begin
      byte_idx_d = last_byte ? '0 : byte_idx_q + 1'b1;
    end
  end

  // Header store; the final byte goes straight to the chain high byte.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (last_byte) begin
        chain_hi_q <= data_byte_i;
      end else begin
        hdr_q[byte_idx_q] <= data_byte_i;
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      rhdc_pkg::ST_RECV:   if (in_fire && last_byte) state_d = rhdc_pkg::ST_MUL_WH;
      rhdc_pkg::ST_MUL_WH: state_d = rhdc_pkg::ST_MUL_CH;
      rhdc_pkg::ST_MUL_CH: state_d = rhdc_pkg::ST_DONE;
      rhdc_pkg::ST_DONE:   state_d = rhdc_pkg::ST_RECV;
      default:             state_d = rhdc_pkg::ST_RECV;
    endcase
  end

  // Channel count is allowed when it lies in one to eight and its mask bit is set.
  assign chan_ok = (dec_chan != 8'd0) && (dec_chan <= rhdc_pkg::MaxChannels) &&
                   chan_mask_q[3'(dec_chan - 8'd1)];

  // Checks that need no product, in priority order.
  always_comb begin
    if (dec_magic != magic_q) begin
      early_d = rhdc_pkg::STATUS_BAD_MAGIC;
    end else if (dec_version != version_q) begin
      early_d = rhdc_pkg::STATUS_BAD_VERSION;
    end else if (dec_plen > max_payload_q) begin
      early_d = rhdc_pkg::STATUS_PAYLOAD_BIG;
    end else if (dec_clen > max_chain_q) begin
      early_d = rhdc_pkg::STATUS_BAD_CHAIN;
    end else if (!chan_ok || dec_width == 32'd0 || dec_height == 32'd0) begin
      early_d = rhdc_pkg::STATUS_LEN_MISMATCH;
    end else begin
      early_d = rhdc_pkg::STATUS_OK;
    end
  end

  // Sequencer outputs: multiplier operands for each step.
  always_comb begin
    mul_req = '0;
    case (state_q)
      rhdc_pkg::ST_MUL_WH: begin
        mul_req.en = 1'b1;
        mul_req.a  = dec_width;
        mul_req.b  = dec_height;
      end
      rhdc_pkg::ST_MUL_CH: begin
        mul_req.en = 1'b1;
        mul_req.a  = mul_prod[31:0];
        mul_req.b  = {24'd0, dec_chan};
      end
      default: ;
    endcase
  end

  rhdc_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (mul_prod)
  );

  // Early status is sampled in the first product step, the overflow of
  // width*height in the second.
  always_ff @(posedge clk_i) begin
    if (state_q == rhdc_pkg::ST_MUL_WH) begin
      early_q <= early_d;
    end
    if (state_q == rhdc_pkg::ST_MUL_CH) begin
      wh_hi_q <= |mul_prod[63:32];
    end
  end

  // Final status and disposition.
  always_comb begin
    if (early_q != rhdc_pkg::STATUS_OK) begin
      status_d = early_q;
    end else if (wh_hi_q || mul_prod != {32'd0, dec_plen}) begin
      status_d = rhdc_pkg::STATUS_LEN_MISMATCH;
    end else begin
      status_d = rhdc_pkg::STATUS_OK;
    end
    case (status_d)
      rhdc_pkg::STATUS_OK:           disp_d = rhdc_pkg::DISP_CONTINUE;
      rhdc_pkg::STATUS_BAD_CHAIN,
      rhdc_pkg::STATUS_LEN_MISMATCH: disp_d = rhdc_pkg::DISP_DRAIN;
      default:                       disp_d = rhdc_pkg::DISP_CLOSE;
    endcase
  end

  // Output valid: set when the result is loaded, cleared when taken.
  assign out_valid_d = (state_q == rhdc_pkg::ST_DONE) ? 1'b1 : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rhdc_pkg::ST_RECV;
      byte_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      byte_idx_q  <= byte_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (state_q == rhdc_pkg::ST_DONE) begin
      status_q <= status_d;
      disp_q   <= disp_d;
      flags_q  <= dec_flags;
      seq_q    <= dec_seq;
      width_q  <= dec_width;
      height_q <= dec_height;
      chan_q   <= dec_chan;
      plen_q   <= dec_plen;
      clen_q   <= dec_clen;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign disposition_o    = disp_q;
  assign flags_o          = flags_q;
  assign sequence_res_o   = seq_q;
  assign img_width_o      = width_q;
  assign img_height_o     = height_q;
  assign channel_count_o  = chan_q;
  assign payload_length_o = plen_q;
  assign chain_length_o   = clen_q;

  // The last byte of a header always starts the product sequence.
  a_last_starts_mul : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last_byte) |=> (state_q == rhdc_pkg::ST_MUL_WH))
    else $error("last header byte did not start the product sequence");

  // A result is only loaded into an empty output register.
  a_done_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rhdc_pkg::ST_DONE) |-> !out_valid_q)
    else $error("result loaded over a waiting result");

  // Continue is given exactly for a clean header.
  a_disp_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((status_o == rhdc_pkg::STATUS_OK) ==
                     (disposition_o == rhdc_pkg::DISP_CONTINUE)))
    else $error("disposition does not match status");

endmodule

`default_nettype wire
